// ===== hw/rtl/tst_pkg.sv =====
package tst_pkg;

  typedef enum logic [1:0] {
    CmdCreate = 2'd0,
    CmdKill   = 2'd1,
    CmdSleep  = 2'd2,
    CmdTick   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    SlotUnused   = 3'd0,
    SlotRunning  = 3'd1,
    SlotReady    = 3'd2,
    SlotSleeping = 3'd3,
    SlotDead     = 3'd4
  } slot_state_e;

  localparam int CmdW      = 2;
  localparam int SlotFldW  = 4;
  localparam int DelayW    = 32;
  localparam int TimeW     = 64;
  localparam int MaskW     = 16;
  localparam int CountFldW = 5;
  localparam int ProdW     = 42;

  localparam logic [9:0] UsPerMs = 10'd1000;

  // control broadcast to every cell
  typedef struct packed {
    logic exec;
    cmd_e cmd;
  } cell_ctl_t;

  // prefix flags handed from one cell to the next
  typedef struct packed {
    logic free;
    logic kill_ok;
  } link_t;

endpackage

// ===== hw/rtl/tst_if.sv =====
interface tst_in_if;
  logic                          valid;
  logic                          ready;
  logic [tst_pkg::CmdW-1:0]      command;
  logic [tst_pkg::SlotFldW-1:0]  target_slot;
  logic [tst_pkg::SlotFldW-1:0]  current_slot;
  logic [tst_pkg::DelayW-1:0]    delay_ms;
  logic [tst_pkg::TimeW-1:0]     now;

  modport source (output valid, command, target_slot, current_slot, delay_ms, now,
                  input ready);
  modport sink   (input valid, command, target_slot, current_slot, delay_ms, now,
                  output ready);
endinterface

interface tst_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [tst_pkg::SlotFldW-1:0]   slot_id;
  logic                           reschedule;
  logic [tst_pkg::MaskW-1:0]      woken_mask;
  logic [tst_pkg::CountFldW-1:0]  used_slots;

  modport source (output valid, status, slot_id, reschedule, woken_mask, used_slots,
                  input ready);
  modport sink   (input valid, status, slot_id, reschedule, woken_mask, used_slots,
                  output ready);
endinterface

// ===== hw/rtl/task_slot_table.sv =====
// Task slot table: one command word in, one result word out. Each slot is a cell holding
// its state and 64-bit wake time; create, kill, sleep and tick act on all cells at once,
// with the lowest-free-slot search and the kill check carried cell to cell along the row.
// A word is accepted only once the last one has left the update step. Each word passes
// through a multiply step, which registers delay_ms x 1000, then an update step, which
// writes the cells and the output register. The result sits in that register, so the next
// word is accepted while it waits; a stalled output holds the update step.
module task_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tst_in_if.sink        in_i,
  tst_out_if.source     out_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StExec = 3'b100
  } fsm_e;

  fsm_e                               state_q, state_d;
  tst_pkg::cmd_e                      cmd_q;
  logic [tst_pkg::SlotFldW-1:0]       target_q, cur_q;
  logic [tst_pkg::DelayW-1:0]         delay_q;
  logic [tst_pkg::TimeW-1:0]          now_q;
  logic [tst_pkg::ProdW-1:0]          prod_q;
  logic [CntW-1:0]                    count_q, count_d;
  logic                               exec_go, cur_ok;
  logic [tst_pkg::TimeW-1:0]          sleep_dl;
  tst_pkg::cell_ctl_t                 ctl;
  tst_pkg::link_t                     link [SLOTS+1];
  logic [IdxW-1:0]                    id [SLOTS+1];
  logic [SLOTS-1:0]                   wake;
  logic [tst_pkg::MaskW-1:0]          mask;

  logic                               ov_q, status_q, resched_q;
  logic [tst_pkg::SlotFldW-1:0]       slot_id_q;
  logic [tst_pkg::MaskW-1:0]          mask_q;
  logic [tst_pkg::CountFldW-1:0]      used_slots_q;
  logic                               status_d, resched_d;
  logic [tst_pkg::SlotFldW-1:0]       slot_id_d;
  logic [tst_pkg::MaskW-1:0]          mask_d;

  assign in_i.ready = (state_q == StIdle);
  assign exec_go    = (state_q == StExec) && (!ov_q || out_o.ready);
  assign cur_ok     = int'(cur_q) < SLOTS;
  assign sleep_dl   = now_q + tst_pkg::TimeW'(prod_q);
  assign ctl.exec   = exec_go;
  assign ctl.cmd    = cmd_q;

  assign link[0] = '0;
  assign id[0]   = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tst_cell #(
      .IDX  (i),
      .IdxW (IdxW),
      .CntW (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .count_i    (count_q),
      .target_i   (target_q),
      .cur_i      (cur_q),
      .now_i      (now_q),
      .sleep_dl_i (sleep_dl),
      .link_i     (link[i]),
      .link_o     (link[i+1]),
      .id_i       (id[i]),
      .id_o       (id[i+1]),
      .wake_o     (wake[i])
    );
  end

  for (genvar i = 0; i < tst_pkg::MaskW; i++) begin : g_mask
    if (i < SLOTS) begin : g_on
      assign mask[i] = wake[i];
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_i.valid) state_d = StMul;
      StMul:  state_d = StExec;
      StExec: if (exec_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    status_d  = 1'b0;
    resched_d = 1'b0;
    slot_id_d = '0;
    mask_d    = '0;
    case (cmd_q)
      tst_pkg::CmdCreate: begin
        if (link[SLOTS].free) begin
          slot_id_d = tst_pkg::SlotFldW'(id[SLOTS]);
          if (CntW'(id[SLOTS]) >= count_q) begin
            count_d = CntW'(id[SLOTS]) + CntW'(1);
          end
        end else begin
          status_d = 1'b1;
        end
      end
      tst_pkg::CmdKill: begin
        status_d  = !link[SLOTS].kill_ok;
        resched_d = link[SLOTS].kill_ok && (target_q == cur_q);
      end
      tst_pkg::CmdSleep: begin
        status_d  = !cur_ok;
        resched_d = cur_ok;
      end
      default: mask_d = mask;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= CntW'(1);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        count_q <= count_d;
        ov_q    <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q    <= tst_pkg::cmd_e'(in_i.command);
      target_q <= in_i.target_slot;
      cur_q    <= in_i.current_slot;
      delay_q  <= in_i.delay_ms;
      now_q    <= in_i.now;
    end
    if (state_q == StMul) begin
      prod_q <= tst_pkg::ProdW'(delay_q) * tst_pkg::ProdW'(tst_pkg::UsPerMs);
    end
    if (exec_go) begin
      status_q     <= status_d;
      slot_id_q    <= slot_id_d;
      resched_q    <= resched_d;
      mask_q       <= mask_d;
      used_slots_q <= tst_pkg::CountFldW'(count_d);
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.status     = status_q;
  assign out_o.slot_id    = slot_id_q;
  assign out_o.reschedule = resched_q;
  assign out_o.woken_mask = mask_q;
  assign out_o.used_slots = used_slots_q;

endmodule

// ===== hw/rtl/tst_cell.sv =====
module tst_cell #(
  parameter int IDX  = 0,
  parameter int IdxW = 4,
  parameter int CntW = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tst_pkg::cell_ctl_t            ctl_i,
  input  logic [CntW-1:0]               count_i,
  input  logic [tst_pkg::SlotFldW-1:0]  target_i,
  input  logic [tst_pkg::SlotFldW-1:0]  cur_i,
  input  logic [tst_pkg::TimeW-1:0]     now_i,
  input  logic [tst_pkg::TimeW-1:0]     sleep_dl_i,
  input  tst_pkg::link_t                link_i,
  output tst_pkg::link_t                link_o,
  input  logic [IdxW-1:0]               id_i,
  output logic [IdxW-1:0]               id_o,
  output logic                          wake_o
);

  localparam tst_pkg::slot_state_e ResetState =
    (IDX == 0) ? tst_pkg::SlotRunning : tst_pkg::SlotUnused;

  tst_pkg::slot_state_e       state_q, state_d;
  logic [tst_pkg::TimeW-1:0]  dl_q, dl_d;
  logic                       is_free, in_scope, live, kill_hit, create_hit, wake;

  always_comb begin
    is_free    = (IDX != 0) &&
                 (state_q == tst_pkg::SlotUnused || state_q == tst_pkg::SlotDead);
    in_scope   = CntW'(IDX) < count_i;
    live       = !(state_q == tst_pkg::SlotUnused || state_q == tst_pkg::SlotDead);
    kill_hit   = (IDX != 0) && in_scope && live && (int'(target_i) == IDX);
    create_hit = is_free && !link_i.free;
    wake       = (state_q == tst_pkg::SlotSleeping) && in_scope && (now_i >= dl_q);

    link_o.free    = link_i.free | is_free;
    link_o.kill_ok = link_i.kill_ok | kill_hit;
    id_o           = create_hit ? (id_i | IdxW'(IDX)) : id_i;
    wake_o         = wake;
  end

  always_comb begin
    state_d = state_q;
    dl_d    = dl_q;
    if (ctl_i.exec) begin
      case (ctl_i.cmd)
        tst_pkg::CmdCreate: begin
          if (create_hit) begin
            state_d = tst_pkg::SlotReady;
            dl_d    = '0;
          end
        end
        tst_pkg::CmdKill: begin
          if (kill_hit) begin
            state_d = tst_pkg::SlotDead;
          end
        end
        tst_pkg::CmdSleep: begin
          if (int'(cur_i) == IDX) begin
            state_d = tst_pkg::SlotSleeping;
            dl_d    = sleep_dl_i;
          end
        end
        default: begin
          if (wake) begin
            state_d = tst_pkg::SlotReady;
            dl_d    = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ResetState;
      dl_q    <= '0;
    end else begin
      state_q <= state_d;
      dl_q    <= dl_d;
    end
  end

endmodule
